// ===== src/acp_pkg.sv =====
// Shared types and constants for the coordinate text parser.
package acp_pkg;

    // Suffix letter codes.
    typedef enum logic [2:0] {
        SUF_NONE = 3'd0,
        SUF_N    = 3'd1,
        SUF_S    = 3'd2,
        SUF_E    = 3'd3,
        SUF_W    = 3'd4
    } suffix_t;

    localparam int unsigned MAX_INT_DIGITS  = 7;
    localparam int unsigned MAX_FRAC_DIGITS = 8;
    localparam int unsigned ANGLE_W         = 41;

    // Parsed text, handed from the front to the back.
    typedef struct packed {
        logic [MAX_INT_DIGITS-1:0][3:0] digits;
        logic [3:0]                     int_count;
        logic [26:0]                    frac_value;
        logic [3:0]                     frac_count;
        logic                           point_seen;
        suffix_t                        suffix;
        logic                           malformed;
    } text_t;

    // Power of ten for up to eight fraction digits.
    function automatic logic [26:0] pow10(input logic [3:0] n);
        logic [26:0] p;
        p = 27'd1;
        for (int i = 0; i < 8; i++) begin
            if (i < int'(n)) begin
                p = 27'(p * 27'd10);
            end
        end
        return p;
    endfunction

endpackage

// ===== src/acp_front.sv =====
// Front part: takes characters and collects one parsed text.
module acp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      s_char,
    input  logic            s_last,
    input  logic            s_valid,
    output logic            s_ready,
    output acp_pkg::text_t  q_data,
    output logic            q_valid,
    input  logic            q_ready
);

    acp_pkg::text_t cur_reg, cur_next;
    acp_pkg::text_t q_reg;
    logic           qv_reg;

    assign s_ready = !qv_reg || q_ready;
    assign q_data  = q_reg;
    assign q_valid = qv_reg;

    // Character classification and text update.
    always_comb begin
        logic [3:0] d;
        cur_next = cur_reg;
        d = 4'(s_char - 8'h30);
        if (cur_reg.suffix != acp_pkg::SUF_NONE) begin
            cur_next.malformed = 1'b1;
        end else if (s_char >= 8'h30 && s_char <= 8'h39) begin
            if (cur_reg.point_seen) begin
                if (cur_reg.frac_count >= 4'd8) begin
                    cur_next.malformed = 1'b1;
                end else begin
                    cur_next.frac_value = 27'(cur_reg.frac_value * 27'd10 + 27'(d));
                    cur_next.frac_count = cur_reg.frac_count + 4'd1;
                end
            end else begin
                if (cur_reg.int_count >= 4'd7) begin
                    cur_next.malformed = 1'b1;
                end else begin
                    cur_next.digits[cur_reg.int_count[2:0]] = d;
                    cur_next.int_count = cur_reg.int_count + 4'd1;
                end
            end
        end else if (s_char == 8'h2E) begin
            if (cur_reg.point_seen || cur_reg.int_count == 4'd0) begin
                cur_next.malformed = 1'b1;
            end else begin
                cur_next.point_seen = 1'b1;
            end
        end else if (s_char == 8'h4E) begin
            cur_next.suffix = acp_pkg::SUF_N;
        end else if (s_char == 8'h53) begin
            cur_next.suffix = acp_pkg::SUF_S;
        end else if (s_char == 8'h45) begin
            cur_next.suffix = acp_pkg::SUF_E;
        end else if (s_char == 8'h57) begin
            cur_next.suffix = acp_pkg::SUF_W;
        end else begin
            cur_next.malformed = 1'b1;
        end
    end

    // Text register and one-entry handoff register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg.int_count  <= '0;
            cur_reg.frac_value <= '0;
            cur_reg.frac_count <= '0;
            cur_reg.point_seen <= 1'b0;
            cur_reg.suffix     <= acp_pkg::SUF_NONE;
            cur_reg.malformed  <= 1'b0;
            qv_reg             <= 1'b0;
        end else begin
            if (s_valid && s_ready && s_last) begin
                qv_reg <= 1'b1;
            end else if (q_ready) begin
                qv_reg <= 1'b0;
            end
            if (s_valid && s_ready) begin
                if (s_last) begin
                    q_reg              <= cur_next;
                    cur_reg.int_count  <= '0;
                    cur_reg.frac_value <= '0;
                    cur_reg.frac_count <= '0;
                    cur_reg.point_seen <= 1'b0;
                    cur_reg.suffix     <= acp_pkg::SUF_NONE;
                    cur_reg.malformed  <= 1'b0;
                end else begin
                    cur_reg <= cur_next;
                end
            end
        end
    end

endmodule

// ===== src/acp_back.sv =====
// Back part: checks a parsed text and converts it to fixed-point degrees.
module acp_back #(
    parameter int FRACTION_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  acp_pkg::text_t                    q_data,
    input  logic                              q_valid,
    output logic                              q_ready,
    output logic [acp_pkg::ANGLE_W-1:0]       m_angle,
    output logic                              m_ok,
    output logic                              m_lon,
    output logic                              m_valid,
    input  logic                              m_ready
);

    localparam int STEPS  = FRACTION_BITS + 1;
    localparam int CNT_W  = $clog2(STEPS + 1);
    localparam int NUM_W  = 48;
    localparam int X_W    = FRACTION_BITS + 10;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_NUM, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    state_t               state_reg;
    acp_pkg::text_t       t_reg;
    logic                 ok_reg, lon_reg, neg_reg;
    logic [NUM_W-1:0]     num_reg, rem_reg;
    logic [NUM_W-1:0]     den_reg;
    logic [X_W-1:0]       x_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [acp_pkg::ANGLE_W-1:0] angle_reg;

    // Field decoding of the held text.
    logic        lon;
    logic [3:0]  dd, n;
    logic [1:0]  units;
    logic        form_ok;
    logic [7:0]  deg;
    logic [5:0]  mins, secs;
    logic        limit, range_ok;
    logic [26:0] p10;
    logic [NUM_W-1:0] whole, num_c, den_c;
    logic [NUM_W:0]   rem_sh;

    always_comb begin
        lon   = t_reg.suffix == acp_pkg::SUF_E || t_reg.suffix == acp_pkg::SUF_W;
        dd    = lon ? 4'd3 : 4'd2;
        n     = t_reg.int_count;
        units = (n == dd + 4'd4) ? 2'd2 : (n == dd + 4'd2) ? 2'd1 : 2'd0;
        form_ok = !t_reg.malformed && t_reg.suffix != acp_pkg::SUF_NONE
                  && (n == dd || n == dd + 4'd2 || n == dd + 4'd4);
        if (t_reg.point_seen && (t_reg.frac_count == 4'd0
                || t_reg.frac_count > ((units == 2'd2) ? 4'd4 : 4'd8))) begin
            form_ok = 1'b0;
        end
        limit    = 1'b0;
        range_ok = 1'b1;
        if (lon) begin
            limit = t_reg.digits[0] == 4'd1 && t_reg.digits[1] == 4'd8
                    && t_reg.digits[2] == 4'd0;
            if (!limit && !(t_reg.digits[0] == 4'd0
                    || (t_reg.digits[0] == 4'd1 && t_reg.digits[1] <= 4'd7))) begin
                range_ok = 1'b0;
            end
            deg = 8'(t_reg.digits[0]) * 8'd100 + 8'(t_reg.digits[1]) * 8'd10
                  + 8'(t_reg.digits[2]);
        end else begin
            limit = t_reg.digits[0] == 4'd9 && t_reg.digits[1] == 4'd0;
            if (!limit && t_reg.digits[0] > 4'd8) begin
                range_ok = 1'b0;
            end
            deg = 8'(t_reg.digits[0]) * 8'd10 + 8'(t_reg.digits[1]);
        end
        mins = '0;
        secs = '0;
        if (units >= 2'd1) begin
            if (t_reg.digits[dd[2:0]] > 4'd5) range_ok = 1'b0;
            mins = 6'(t_reg.digits[dd[2:0]] * 6'd10 + 6'(t_reg.digits[3'(dd + 4'd1)]));
        end
        if (units == 2'd2) begin
            if (t_reg.digits[3'(dd + 4'd2)] > 4'd5) range_ok = 1'b0;
            secs = 6'(t_reg.digits[3'(dd + 4'd2)] * 6'd10
                   + 6'(t_reg.digits[3'(dd + 4'd3)]));
        end
        if (limit && (mins != 0 || secs != 0 || t_reg.frac_value != 0)) begin
            range_ok = 1'b0;
        end
        p10 = acp_pkg::pow10(t_reg.frac_count);
        case (units)
            2'd2:    whole = NUM_W'(deg) * 48'd3600 + NUM_W'(mins) * 48'd60 + NUM_W'(secs);
            2'd1:    whole = NUM_W'(deg) * 48'd60 + NUM_W'(mins);
            default: whole = NUM_W'(deg);
        endcase
        case (units)
            2'd2:    den_c = NUM_W'(p10) * 48'd3600;
            2'd1:    den_c = NUM_W'(p10) * 48'd60;
            default: den_c = NUM_W'(p10);
        endcase
        num_c  = NUM_W'(whole[19:0]) * NUM_W'(p10);
        rem_sh = {rem_reg, 1'b0};
    end

    assign q_ready = state_reg == ST_IDLE;
    assign m_valid = state_reg == ST_OUT;
    assign m_angle = angle_reg;
    assign m_ok    = ok_reg;
    assign m_lon   = lon_reg;

    // Sequencer: check, build ratio, long division one bit a cycle, round.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        t_reg     <= q_data;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    ok_reg  <= form_ok && range_ok;
                    lon_reg <= form_ok && range_ok && lon;
                    neg_reg <= t_reg.suffix == acp_pkg::SUF_S
                               || t_reg.suffix == acp_pkg::SUF_W;
                    den_reg <= den_c;
                    num_reg <= num_c;
                    if (form_ok && range_ok) begin
                        state_reg <= ST_NUM;
                    end else begin
                        angle_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_NUM: begin
                    // Integer part is the whole units scaled down: quotient = degrees.
                    x_reg     <= X_W'(deg);
                    rem_reg   <= num_reg + NUM_W'(t_reg.frac_value)
                                 - NUM_W'(deg) * den_reg;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (rem_sh >= {1'b0, den_reg}) begin
                        rem_reg <= NUM_W'(rem_sh - {1'b0, den_reg});
                        x_reg   <= {x_reg[X_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[NUM_W-1:0];
                        x_reg   <= {x_reg[X_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(STEPS - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    angle_reg <= neg_reg
                        ? acp_pkg::ANGLE_W'(-((x_reg + 1'b1) >> 1))
                        : acp_pkg::ANGLE_W'((x_reg + 1'b1) >> 1);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // An invalid result always carries a zero angle and no longitude flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_angle == '0 && !m_lon)
        else $error("invalid result with nonzero payload");
    // A result is held while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_angle))
        else $error("result dropped under stall");
    // The divider never runs past its step count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> cnt_reg < CNT_W'(STEPS))
        else $error("division step overrun");

endmodule

// ===== src/aixm_coordinate_text_parser.sv =====
// Top level of the coordinate text parser.
//
// Input: one ASCII character per item on s_axis (tdata), s_axis_tlast on
// the final character of a text. Each text yields exactly one item on m_axis:
// tdata holds the signed angle in degrees with FRACTION_BITS fraction bits,
// tuser holds the valid flag and the longitude flag.
// A front part takes one character per cycle, unless its one-entry handoff
// register is full and the back part busy, and hands a completed text to
// a back part through that register, so the next text streams in while
// the previous one is converted. The back part checks, sets up, runs a
// shift-subtract divider that yields one quotient bit per cycle, rounds,
// and then presents the output; that divider sets the pace for short texts.
// Reset clears all control state; no result is pending afterward.
// When m_axis_tready is low the result is held, the back part stops, and
// once the handoff register is full s_axis_tready drops.
module aixm_coordinate_text_parser #(
    parameter int FRACTION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_char
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // angle_degrees [40:0], zeros above
    output logic [1:0]  m_axis_tuser    // valid_res [0], is_longitude [1]
);

    acp_pkg::text_t q_data;
    logic           q_valid, q_ready;
    logic [acp_pkg::ANGLE_W-1:0] angle;
    logic           ok, lon;

    acp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_char  (s_axis_tdata),
        .s_last  (s_axis_tlast),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    acp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .m_angle (angle),
        .m_ok    (ok),
        .m_lon   (lon),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, angle};
    assign m_axis_tuser = {lon, ok};

endmodule

// ===== dv/aixm_coordinate_text_parser_checker.sv =====
// Checker for the coordinate text parser: predicts each result and compares it.
`timescale 1ns / 1ps
module aixm_coordinate_text_parser_checker #(
    parameter int FRACTION_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    output int          fail_count,
    output int          pending_count,
    output int          texts_seen,
    output int          valid_seen
);

    typedef struct packed {
        logic [40:0] angle;
        logic        ok;
        logic        lon;
    } coord_t;

    coord_t     pending_coords[$];
    logic [3:0] digs[acp_pkg::MAX_INT_DIGITS];
    int         n_int;
    logic [26:0] frac_val;
    int         n_frac;
    logic       has_point;
    acp_pkg::suffix_t suf;
    logic       bad;

    task automatic report(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic void clear_text();
        for (int i = 0; i < acp_pkg::MAX_INT_DIGITS; i++) digs[i] = '0;
        n_int = 0;
        frac_val = '0;
        n_frac = 0;
        has_point = 1'b0;
        suf = acp_pkg::SUF_NONE;
        bad = 1'b0;
    endfunction

    function automatic void take_char(input logic [7:0] c);
        if (suf != acp_pkg::SUF_NONE) begin
            bad = 1'b1;
        end else if (c >= "0" && c <= "9") begin
            if (has_point) begin
                if (n_frac >= acp_pkg::MAX_FRAC_DIGITS) begin
                    bad = 1'b1;
                end else begin
                    frac_val = 27'(frac_val * 10 + (c - "0"));
                    n_frac++;
                end
            end else if (n_int >= acp_pkg::MAX_INT_DIGITS) begin
                bad = 1'b1;
            end else begin
                digs[n_int] = 4'(c - "0");
                n_int++;
            end
        end else if (c == ".") begin
            if (has_point || n_int == 0) bad = 1'b1;
            else has_point = 1'b1;
        end else if (c == "N") suf = acp_pkg::SUF_N;
        else if (c == "S") suf = acp_pkg::SUF_S;
        else if (c == "E") suf = acp_pkg::SUF_E;
        else if (c == "W") suf = acp_pkg::SUF_W;
        else bad = 1'b1;
    endfunction

    // Convert the collected text into the expected angle.
    function automatic coord_t convert_text();
        coord_t res;
        logic lon, at_limit;
        int dd, units, maxf, deg, mins, secs;
        logic [63:0] num, den, q, r, p10, mag;
        res = '0;
        mins = 0;
        secs = 0;
        at_limit = 1'b0;
        if (bad || suf == acp_pkg::SUF_NONE) return res;
        lon = (suf == acp_pkg::SUF_E || suf == acp_pkg::SUF_W);
        dd = lon ? 3 : 2;
        if (n_int != dd && n_int != dd + 2 && n_int != dd + 4) return res;
        units = (n_int - dd) / 2;
        if (has_point) begin
            maxf = (units == 2) ? 4 : 8;
            if (n_frac == 0 || n_frac > maxf) return res;
        end
        if (lon) begin
            if (digs[0] == 1 && digs[1] == 8 && digs[2] == 0) at_limit = 1'b1;
            else if (!(digs[0] == 0 || (digs[0] == 1 && digs[1] <= 7))) return res;
            deg = digs[0] * 100 + digs[1] * 10 + digs[2];
        end else begin
            if (digs[0] == 9 && digs[1] == 0) at_limit = 1'b1;
            else if (digs[0] > 8) return res;
            deg = digs[0] * 10 + digs[1];
        end
        if (units >= 1) begin
            if (digs[dd] > 5) return res;
            mins = digs[dd] * 10 + digs[dd+1];
        end
        if (units == 2) begin
            if (digs[dd+2] > 5) return res;
            secs = digs[dd+2] * 10 + digs[dd+3];
        end
        if (at_limit && (mins != 0 || secs != 0 || frac_val != 0)) return res;
        p10 = 1;
        for (int i = 0; i < n_frac; i++) p10 = p10 * 10;
        if (units == 2) begin
            num = (64'(deg) * 3600 + mins * 60 + secs) * p10 + frac_val;
            den = 3600 * p10;
        end else if (units == 1) begin
            num = (64'(deg) * 60 + mins) * p10 + frac_val;
            den = 60 * p10;
        end else begin
            num = 64'(deg) * p10 + frac_val;
            den = p10;
        end
        // Long division to one extra bit, then round half up.
        q = num / den;
        r = num % den;
        for (int i = 0; i < FRACTION_BITS + 1; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        mag = (q + 1) >> 1;
        if (suf == acp_pkg::SUF_S || suf == acp_pkg::SUF_W) mag = -mag;
        res.angle = mag[40:0];
        res.ok = 1'b1;
        res.lon = lon;
        return res;
    endfunction

    assign pending_count = pending_coords.size();

    // Predict on accepted characters; compare on accepted results.
    always @(posedge aclk) begin
        coord_t got, want;
        if (!aresetn) begin
            clear_text();
            pending_coords.delete();
            fail_count = 0;
            texts_seen <= 0;
            valid_seen <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_char(s_axis_tdata);
                if (s_axis_tlast) begin
                    pending_coords.push_back(convert_text());
                    clear_text();
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.angle = m_axis_tdata[40:0];
                got.ok = m_axis_tuser[0];
                got.lon = m_axis_tuser[1];
                texts_seen <= texts_seen + 1;
                if (got.ok) valid_seen <= valid_seen + 1;
                if (pending_coords.size() == 0) begin
                    report("result with no text pending");
                end else begin
                    want = pending_coords.pop_front();
                    if (got.angle !== want.angle || m_axis_tdata[47:41] !== '0)
                        report($sformatf("angle got %h want %h",
                                         m_axis_tdata, want.angle));
                    if (got.ok !== want.ok)
                        report($sformatf("valid got %b want %b", got.ok, want.ok));
                    if (got.lon !== want.lon)
                        report($sformatf("longitude got %b want %b",
                                         got.lon, want.lon));
                end
            end
        end
    end

endmodule

// ===== dv/aixm_coordinate_text_parser_tb.sv =====
// Testbench top for the coordinate text parser: stimulus and verdict.
`timescale 1ns / 1ps
module aixm_coordinate_text_parser_tb;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          fail_count, pending_count, texts_seen, valid_seen;
    int          chars_sent = 0;
    int          idle_cycles = 0;
    logic        stim_done = 1'b0;

    always #5 aclk = ~aclk;

    aixm_coordinate_text_parser uut (.*);

    aixm_coordinate_text_parser_checker chk (.*);

    // Watchdog: cycles without any accepted item.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results pending", pending_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver stalls for a random gap before each result, sometimes none.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Send one character, after a random gap unless burst mode.
    task automatic send_char(input logic [7:0] c, input logic last, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(input string txt, input bit burst);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], i == txt.len() - 1, burst);
    endtask

    function automatic string digits_of(input int n, input int maxv);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, maxv)))};
        return s;
    endfunction

    // A well-formed-looking coordinate with random content and occasional damage.
    function automatic string random_coord();
        string s, sfx;
        bit lon;
        int units, nf;
        lon = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: s = lon ? "180" : "90";
            1: s = lon ? "179" : "89";
            2: s = lon ? "000" : "00";
            default: s = lon ? $sformatf("%03d", $urandom_range(0, 199))
                             : $sformatf("%02d", $urandom_range(0, 99));
        endcase
        units = $urandom_range(0, 2);
        for (int u = 0; u < units; u++)
            s = {s, ($urandom_range(0, 5) == 0) ? "59" : digits_of(1, 6), digits_of(1, 9)};
        if ($urandom_range(0, 1)) begin
            nf = $urandom_range(0, 9);
            s = {s, ".", ($urandom_range(0, 2) == 0) ? digits_of(nf, 0) : digits_of(nf, 9)};
        end
        sfx = lon ? (($urandom_range(0, 1)) ? "E" : "W") : (($urandom_range(0, 1)) ? "N" : "S");
        if ($urandom_range(0, 12) == 0) sfx = (sfx == "E") ? "N" : "E";
        s = {s, sfx};
        if ($urandom_range(0, 15) == 0) s = {s, "N"};
        return s;
    endfunction

    function automatic string noise_text();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 255)))};
        return s;
    endfunction

    initial begin
        string directed[$];
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: limits, each suffix, and the malformed forms.
        directed = '{"90N", "90S", "180E", "180W", "8959.99999999N", "1795959.9999E",
                     "000000.0000S", "00W", "90.1N", "1800001E", "91N", "181E", "4560N",
                     "453060N", ".5N", "45..5N", "45.N", "45NN", "45N5", "12345678N",
                     "45.123456789N", "1234N", "45", "45x N", "453030.12345N"};
        foreach (directed[i]) send_text(directed[i], 1'(i % 2));

        // Hold off until every expected result has come.
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        send_char(8'hFF, 1'b1, 1'b1);
        send_char(8'h00, 1'b1, 1'b1);

        // Random: mostly coordinates, some noise; bursts with no gaps.
        while (chars_sent < 1600) begin
            if ($urandom_range(0, 7) == 0) send_text(noise_text(), 1'b0);
            else send_text(random_coord(), $urandom_range(0, 3) == 0);
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        $display("Sent %0d characters; %0d texts converted, %0d of them valid.",
                 chars_sent, texts_seen, valid_seen);
        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/acp_pkg.sv
src/acp_front.sv
src/acp_back.sv
src/aixm_coordinate_text_parser.sv
dv/aixm_coordinate_text_parser_checker.sv
dv/aixm_coordinate_text_parser_tb.sv
